### sv/gbvb_pkg.sv
// gbvb_pkg: shared types, codes and constant tables for the gaussian brush blend
// no dependencies
`default_nettype none
package gbvb_pkg;

    localparam logic [22:0] GAUSS_COEF_Q24 = 23'd6693141;

    typedef enum logic [1:0] {
        MODE_BIAS  = 2'd0,
        MODE_BRUSH = 2'd1,
        MODE_QUERY = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        CFG_POINT_COUNT = 2'd0,
        CFG_SLICE_COUNT = 2'd1,
        CFG_BIAS_WEIGHT = 2'd2
    } t_cfg_idx;

    // back end sequencer states
    typedef enum logic [3:0] {
        ST_IDLE, ST_BIAS, ST_WALK, ST_DIV, ST_WAIT, ST_EMIT
    } t_back_state;

    typedef struct packed {
        logic [1:0]  mode;
        logic [5:0]  entry_index;
        logic [1:0]  slice_select;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] variance;
        logic [15:0] red_in;
        logic [15:0] green_in;
        logic [15:0] blue_in;
        logic [15:0] alpha_in;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  slice_out;
        logic [15:0] red_out;
        logic [15:0] green_out;
        logic [15:0] blue_out;
        logic [15:0] alpha_out;
        logic        was_normalized;
        logic        last_slice;
    } t_out_item;

    // front to back: one classified query
    typedef struct packed {
        logic [15:0] qx;
        logic [15:0] qy;
        logic [10:0] npts;
        logic [4:0]  nslc;
    } t_query;

    // exp(-i*16/depth) in Q0.16: truncating taylor series, then four squarings
    function automatic logic [15:0] exp_entry(input int unsigned i, input int unsigned depth);
        logic [63:0] s;
        logic [63:0] t;
        logic [63:0] y;
        logic [63:0] q;
        s = 64'h1_0000_0000;
        t = 64'h1_0000_0000;
        y = (64'(i) << 32) / 64'(depth);
        for (int k = 1; k <= 20; k++) begin
            t = ((t * y) >> 32) / 64'(k);
            if (k % 2 == 1) s = (s >= t) ? s - t : 64'd0;
            else s = s + t;
        end
        if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
        for (int r = 0; r < 4; r++) s = (s * s) >> 32;
        q = (s + 64'h8000) >> 16;
        return (q > 64'd65535) ? 16'hFFFF : q[15:0];
    endfunction

endpackage
`default_nettype wire

### sv/gbvb_ram.sv
// gbvb_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module gbvb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### sv/gbvb_div.sv
// gbvb_div: restoring divider, one quotient bit per cycle, 64 by 49 bits
// no dependencies
`default_nettype none
module gbvb_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_num,
    input  wire logic [48:0] i_den,
    output      logic        o_done,
    output      logic [63:0] o_quo
);
    logic [63:0] r_quo, n_quo;
    logic [49:0] r_rem, n_rem;
    logic [48:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [49:0] shifted;

    always_comb begin
        shifted = {r_rem[48:0], r_quo[63]};
        n_quo   = {r_quo[62:0], 1'b0};
        n_rem   = shifted;
        if (shifted >= {1'b0, r_den}) begin
            n_rem    = shifted - {1'b0, r_den};
            n_quo[0] = 1'b1;
        end
    end

    // iterate 64 steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_quo <= n_quo;
                r_rem <= n_rem;
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_quo = r_quo;
endmodule
`default_nettype wire

### sv/gbvb_front.sv
// gbvb_front: accepts items, performs loads, queues queries for the back end
// depends on gbvb_pkg; drives the gbvb_ram write enables through the top level
`default_nettype none
module gbvb_front import gbvb_pkg::*; #(
    parameter int MAX_POINTS = 64,
    parameter int MAX_SLICES = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire t_in_item    i_item,
    input  wire logic [6:0]  i_point_count,
    input  wire logic [2:0]  i_slice_count,
    input  wire logic        i_back_busy,
    output      logic        o_busy,
    output      logic        o_brush_we,
    output      logic        o_bias_we,
    output      logic        o_q_valid,
    output      t_query      o_q,
    input  wire logic        i_q_pop
);
    localparam int SLIM = (MAX_SLICES < 4) ? MAX_SLICES : 4;
    localparam int QD   = 2;

    t_query     r_q [QD];
    logic [1:0] r_cnt;
    logic       r_wr, r_rd;
    logic       acc;
    logic       push;
    t_query     nq;
    logic [2:0] s;

    assign acc    = i_start && !o_busy;
    // hold off items while a query is queued or worked, so loads stay in order
    assign o_busy = (r_cnt != 2'd0) || i_back_busy;
    assign o_brush_we = acc && (i_item.mode == MODE_BRUSH)
                        && (32'(i_item.entry_index) < MAX_POINTS)
                        && (32'(i_item.slice_select) < MAX_SLICES);
    assign o_bias_we  = acc && (i_item.mode == MODE_BIAS)
                        && (32'(i_item.slice_select) < MAX_SLICES);
    assign push = acc && (i_item.mode == MODE_QUERY);

    // clamp counts for the query
    always_comb begin
        s = i_slice_count;
        if (s == 3'd0) s = 3'd1;
        if (32'(s) > SLIM) s = 3'(SLIM);
        nq.qx   = i_item.pos_x;
        nq.qy   = i_item.pos_y;
        nq.npts = (32'(i_point_count) > MAX_POINTS) ? 11'(MAX_POINTS) : 11'(i_point_count);
        nq.nslc = 5'(s);
    end

    // two-entry query queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
        end else begin
            if (push) begin
                r_q[r_wr] <= nq;
                r_wr      <= ~r_wr;
            end
            if (i_q_pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q       = r_q[r_rd];
endmodule
`default_nettype wire

### sv/gbvb_back.sv
// gbvb_back: per slice, walks brush points, accumulates weighted sums, divides
// depends on gbvb_pkg, gbvb_div; reads brush rams through the top level
`default_nettype none
module gbvb_back import gbvb_pkg::*; #(
    parameter int MAX_POINTS = 64,
    parameter int MAX_SLICES = 4,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_q_valid,
    input  wire t_query      i_q,
    output      logic        o_q_pop,
    output      logic        o_busy,
    input  wire logic [15:0] i_bias_weight,
    input  wire logic [63:0] i_bias_color,
    output      logic [$clog2(MAX_POINTS)-1:0] o_pt_addr,
    output      logic [$clog2(MAX_POINTS*MAX_SLICES)-1:0] o_col_addr,
    output      logic [$clog2(MAX_SLICES > 1 ? MAX_SLICES : 2)-1:0] o_slice,
    input  wire logic [31:0] i_pos,
    input  wire logic [15:0] i_spread,
    input  wire logic [63:0] i_color,
    output      logic        o_valid,
    output      t_out_item   o_item
);
    localparam int PW = $clog2(MAX_POINTS);
    localparam int SW = $clog2(MAX_SLICES > 1 ? MAX_SLICES : 2);
    localparam int TW = $clog2(EXP_TABLE_DEPTH);
    localparam int LD = $clog2(EXP_TABLE_DEPTH);
    localparam int RW = TW + 33;

    t_back_state r_st, n_st;
    t_query r_q;
    logic [10:0] r_pidx;      // issue index
    logic [4:0]  r_sl;
    logic [1:0]  r_dch;

    // exp table
    logic [15:0] exp_rom [EXP_TABLE_DEPTH];
    always_comb
        for (int i = 0; i < EXP_TABLE_DEPTH; i++) exp_rom[i] = exp_entry(i, EXP_TABLE_DEPTH);

    // per point sub-sequencer registers
    logic [31:0] r_dx2, r_dy2, r_v2;
    logic [15:0] r_vs;
    logic [63:0] r_colq;
    logic [2:0]  r_ph;
    logic [32:0] r_d;
    logic [47:0] r_thr;
    logic [TW:0] r_idx;
    logic [4:0]  r_bit;
    logic [22:0] r_coef;
    logic [23:0] r_crem;
    logic [31:0] r_w;
    logic [47:0] r_int;
    logic [63:0] r_acc_r, r_acc_g, r_acc_b;
    logic [63:0] r_acc_a;
    logic [63:0] r_prod;
    logic [1:0]  r_mch;

    // weight unit: index search and coefficient divide, bit-serial
    // index = largest k with k*V^2*2^21 <= d*DEPTH, found by binary search bits
    logic [63:0] lhs, rhs;
    logic [24:0] cshift;
    always_comb begin
        lhs = 64'(r_d) << LD;
        rhs = 64'(RW'(r_idx | (TW+1)'(1 << r_bit)) * RW'(r_v2)) << 21;
        cshift = {r_crem, r_coef[22]};
    end

    logic div_start, div_done;
    logic [63:0] div_num, div_quo;
    logic [48:0] div_den;
    gbvb_div u_div (
        .i_clk, .i_rst_n, .i_start(div_start), .i_num(div_num), .i_den(div_den),
        .o_done(div_done), .o_quo(div_quo)
    );

    logic [15:0] r_res [3];
    logic        r_norm;

    // point phases: 0 address issue or color product, 1 ram read, 2 squares,
    // 3 distance sum, 4 search and divide, 5 weight, 7 intensity, 6 product add
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= ST_IDLE;
            o_valid <= 1'b0;
        end else begin
            r_st    <= n_st;
            o_valid <= 1'b0;
            case (r_st)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_q  <= i_q;
                        r_sl <= '0;
                    end
                end
                ST_BIAS: begin
                    // bias weight times alpha
                    r_acc_a <= 64'(48'(i_bias_color[15:0]) * 48'({i_bias_weight, 16'd0}));
                    r_acc_r <= '0; r_acc_g <= '0; r_acc_b <= '0;
                    r_pidx  <= '0;
                    r_ph    <= '0;
                    r_colq  <= i_bias_color;
                    r_int   <= 48'(i_bias_color[15:0]) * 48'({i_bias_weight, 16'd0});
                    r_mch   <= '0;
                end
                ST_WALK: begin
                    case (r_ph)
                        3'd0: begin
                            // color products of the current source, then next point
                            if (r_mch != 2'd3) begin
                                r_prod <= 64'(r_colq[63 - 16*r_mch -: 16]) * 64'(r_int);
                                r_ph   <= 3'd6;
                            end else if (r_pidx < r_q.npts) begin
                                r_ph <= 3'd1;  // address issued this cycle
                            end
                        end
                        3'd1: r_ph <= 3'd2;  // ram read
                        3'd2: begin
                            r_dx2 <= (i_pos[31:16] > r_q.qx ? i_pos[31:16] - r_q.qx : r_q.qx - i_pos[31:16])
                                   * (i_pos[31:16] > r_q.qx ? i_pos[31:16] - r_q.qx : r_q.qx - i_pos[31:16]);
                            r_dy2 <= (i_pos[15:0] > r_q.qy ? i_pos[15:0] - r_q.qy : r_q.qy - i_pos[15:0])
                                   * (i_pos[15:0] > r_q.qy ? i_pos[15:0] - r_q.qy : r_q.qy - i_pos[15:0]);
                            r_v2   <= 32'(i_spread) * 32'(i_spread);
                            r_vs   <= i_spread;
                            r_colq <= i_color;
                            r_ph   <= 3'd3;
                        end
                        3'd3: begin
                            r_d    <= 33'(r_dx2) + 33'(r_dy2);
                            r_idx  <= '0;
                            r_bit  <= 5'(TW);
                            r_coef <= GAUSS_COEF_Q24;
                            r_crem <= '0;
                            r_ph   <= 3'd4;
                        end
                        3'd4: begin
                            // one index bit and one coefficient bit per cycle
                            if (rhs <= lhs) r_idx <= r_idx | (TW+1)'(1 << r_bit);
                            if (r_bit != 0) r_bit <= r_bit - 5'd1;
                            if ({15'd0, cshift} >= 40'(r_vs)) begin
                                r_crem <= 24'(cshift - 25'(r_vs));
                                r_coef <= {r_coef[21:0], 1'b1};
                            end else begin
                                r_crem <= cshift[23:0];
                                r_coef <= {r_coef[21:0], 1'b0};
                            end
                            r_thr <= r_thr + 48'd1;
                            if (r_thr[4:0] == 5'd22) r_ph <= 3'd5;
                        end
                        3'd5: begin
                            if (r_vs == 16'd0 || r_idx >= (TW+1)'(EXP_TABLE_DEPTH)) r_w <= '0;
                            else r_w <= 32'((40'(r_coef) * 40'(exp_rom[r_idx[TW-1:0]])) >> 16);
                            r_ph <= 3'd7;
                        end
                        3'd7: begin
                            r_int   <= 48'(r_colq[15:0]) * 48'(r_w);
                            r_acc_a <= r_acc_a + 64'(48'(r_colq[15:0]) * 48'(r_w));
                            r_mch   <= '0;
                            r_pidx  <= r_pidx + 11'd1;
                            r_ph    <= 3'd0;
                        end
                        3'd6: begin
                            case (r_mch)
                                2'd0: r_acc_r <= r_acc_r + r_prod;
                                2'd1: r_acc_g <= r_acc_g + r_prod;
                                default: r_acc_b <= r_acc_b + r_prod;
                            endcase
                            r_mch <= r_mch + 2'd1;
                            r_ph  <= 3'd0;
                        end
                        default: r_ph <= 3'd0;
                    endcase
                    if (r_ph != 3'd4) r_thr <= '0;
                end
                ST_DIV: begin
                    r_dch <= '0;
                    r_norm <= (r_acc_a != 0);
                end
                ST_WAIT: begin
                    if (div_done) begin
                        r_res[r_dch] <= (div_quo > 64'd65535) ? 16'hFFFF : div_quo[15:0];
                        r_dch <= r_dch + 2'd1;
                    end
                end
                ST_EMIT: begin
                    o_valid <= 1'b1;
                    o_item.slice_out <= r_sl[1:0];
                    o_item.was_normalized <= r_norm;
                    o_item.last_slice <= (r_sl + 5'd1 == r_q.nslc);
                    if (r_norm) begin
                        o_item.red_out   <= r_res[0];
                        o_item.green_out <= r_res[1];
                        o_item.blue_out  <= r_res[2];
                        o_item.alpha_out <= 16'hFFFF;
                    end else begin
                        o_item.red_out   <= (r_acc_r[63:32] > 32'd65535) ? 16'hFFFF : r_acc_r[47:32];
                        o_item.green_out <= (r_acc_g[63:32] > 32'd65535) ? 16'hFFFF : r_acc_g[47:32];
                        o_item.blue_out  <= (r_acc_b[63:32] > 32'd65535) ? 16'hFFFF : r_acc_b[47:32];
                        o_item.alpha_out <= (r_acc_a[63:16] > 48'd65535) ? 16'hFFFF : r_acc_a[31:16];
                    end
                    r_sl <= r_sl + 5'd1;
                end
                default: ;
            endcase
        end
    end

    // divider feed: red first, then the channel after the one just finished
    logic [1:0] dsel;
    always_comb begin
        dsel = (r_st == ST_WAIT) ? r_dch + 2'd1 : 2'd0;
        case (dsel)
            2'd0: div_num = r_acc_r;
            2'd1: div_num = r_acc_g;
            default: div_num = r_acc_b;
        endcase
        div_den = r_acc_a[48:0];
        div_start = ((r_st == ST_DIV) && (r_acc_a != 0))
                 || ((r_st == ST_WAIT) && div_done && r_dch != 2'd2);
    end

    // sequencer
    always_comb begin
        n_st    = r_st;
        o_q_pop = 1'b0;
        case (r_st)
            ST_IDLE: if (i_q_valid) begin
                o_q_pop = 1'b1;
                n_st = ST_BIAS;
            end
            ST_BIAS: n_st = ST_WALK;
            ST_WALK: if (r_ph == 3'd0 && r_mch == 2'd3 && r_pidx >= r_q.npts) n_st = ST_DIV;
            ST_DIV:  n_st = (r_acc_a != 0) ? ST_WAIT : ST_EMIT;
            ST_WAIT: if (div_done && r_dch == 2'd2) n_st = ST_EMIT;
            ST_EMIT: n_st = (r_sl + 5'd1 == r_q.nslc) ? ST_IDLE : ST_BIAS;
            default: n_st = ST_IDLE;
        endcase
    end

    assign o_busy     = (r_st != ST_IDLE);
    assign o_slice    = SW'(r_sl);
    assign o_pt_addr  = PW'(r_pidx);
    assign o_col_addr = (PW+SW)'((32'(r_pidx) * MAX_SLICES) + 32'(r_sl));
endmodule
`default_nettype wire

### sv/gaussian_brush_vertex_blend.sv
// gaussian_brush_vertex_blend: top level, config registers, stores, front and back
// depends on gbvb_pkg, gbvb_ram, gbvb_front, gbvb_back
//
// usage:
//   command channel: present an item with start high while busy is low; it is
//   taken at that edge. loads (mode 0/1) finish in the front at once; a query is
//   queued for the back end and busy stays high until its last slice result.
//   config channel: i_cfg_valid/o_cfg_ready with index and data, always ready;
//   write only while the block is idle.
//   results: one per slice, shown for one cycle with o_valid; cannot be stalled.
//   sequence: the query is taken from the queue; then per slice the back end
//   works on the bias color, then on each brush point (23-step index search and
//   coefficient divide, weight, three color products), then runs three divides
//   when the alpha sum is nonzero.
//   ordering: the next item is taken at the earliest in the cycle of the last
//   slice result of a query; a load does not raise busy.
//   reset: config to point_count 0, slice_count 2, bias_weight 65535; bias
//   colors read as zero until loaded; brush entries are undefined until loaded.
`default_nettype none
module gaussian_brush_vertex_blend import gbvb_pkg::*; #(
    parameter int MAX_POINTS = 64,
    parameter int MAX_SLICES = 4,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output      logic        busy,
    input  wire t_in_item    i_item,
    output      logic        o_valid,
    output      t_out_item   o_item,
    input  wire logic        i_cfg_valid,
    output      logic        o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    localparam int PW = $clog2(MAX_POINTS);
    localparam int SW = $clog2(MAX_SLICES > 1 ? MAX_SLICES : 2);

    logic [6:0]  r_point_count;
    logic [2:0]  r_slice_count;
    logic [15:0] r_bias_weight;
    logic [63:0] r_bias [MAX_SLICES];
    logic [MAX_SLICES-1:0] r_bias_ok;

    assign o_cfg_ready = 1'b1;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= '0;
            r_slice_count <= 3'd2;
            r_bias_weight <= 16'hFFFF;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_POINT_COUNT: r_point_count <= i_cfg_data[6:0];
                CFG_SLICE_COUNT: r_slice_count <= i_cfg_data[2:0];
                CFG_BIAS_WEIGHT: r_bias_weight <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic brush_we, bias_we, q_valid, q_pop, back_busy;
    t_query q;
    gbvb_front #(.MAX_POINTS(MAX_POINTS), .MAX_SLICES(MAX_SLICES)) u_front (
        .i_clk, .i_rst_n, .i_start(start), .i_item,
        .i_point_count(r_point_count), .i_slice_count(r_slice_count),
        .i_back_busy(back_busy),
        .o_busy(busy), .o_brush_we(brush_we), .o_bias_we(bias_we),
        .o_q_valid(q_valid), .o_q(q), .i_q_pop(q_pop)
    );

    // bias colors with valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_bias_ok <= '0;
        else if (bias_we) r_bias_ok[SW'(i_item.slice_select)] <= 1'b1;
        if (bias_we) r_bias[SW'(i_item.slice_select)] <=
            {i_item.red_in, i_item.green_in, i_item.blue_in, i_item.alpha_in};
    end

    logic [PW-1:0] pt_addr;
    logic [PW+SW-1:0] col_addr;
    logic [SW-1:0] slc;
    logic [31:0] pos;
    logic [15:0] spread;
    logic [63:0] color;
    logic [63:0] bias_col;
    assign bias_col = r_bias_ok[slc] ? r_bias[slc] : 64'd0;

    gbvb_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_pos (
        .i_clk, .i_we(brush_we), .i_waddr(PW'(i_item.entry_index)),
        .i_wdata({i_item.pos_x, i_item.pos_y}), .i_raddr(pt_addr), .o_rdata(pos)
    );
    gbvb_ram #(.WIDTH(16), .DEPTH(MAX_POINTS)) u_spr (
        .i_clk, .i_we(brush_we), .i_waddr(PW'(i_item.entry_index)),
        .i_wdata(i_item.variance), .i_raddr(pt_addr), .o_rdata(spread)
    );
    gbvb_ram #(.WIDTH(64), .DEPTH(MAX_POINTS*MAX_SLICES)) u_col (
        .i_clk, .i_we(brush_we),
        .i_waddr((PW+SW)'(32'(i_item.entry_index) * MAX_SLICES + 32'(i_item.slice_select))),
        .i_wdata({i_item.red_in, i_item.green_in, i_item.blue_in, i_item.alpha_in}),
        .i_raddr(col_addr), .o_rdata(color)
    );

    gbvb_back #(.MAX_POINTS(MAX_POINTS), .MAX_SLICES(MAX_SLICES),
                .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .i_q(q), .o_q_pop(q_pop),
        .o_busy(back_busy),
        .i_bias_weight(r_bias_weight), .i_bias_color(bias_col),
        .o_pt_addr(pt_addr), .o_col_addr(col_addr), .o_slice(slc),
        .i_pos(pos), .i_spread(spread), .i_color(color),
        .o_valid, .o_item
    );
endmodule
`default_nettype wire

### sv/gbvb_checker.sv
// gbvb_checker: port-level checks on the blend block
// depends on gbvb_pkg; bound to gaussian_brush_vertex_blend
`default_nettype none
module gbvb_checker import gbvb_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_valid,
    input wire t_out_item i_item
);
    // normalized results carry alpha one
    a_norm_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_item.was_normalized |-> i_item.alpha_out == 16'hFFFF)
        else $error("normalized alpha not one");
    // results never come on consecutive cycles
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |=> !i_valid) else $error("back-to-back results");
    // slice three is always the last slice of a query
    a_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_item.last_slice == 1'b0 |-> i_item.slice_out != 2'd3)
        else $error("slice past limit");
endmodule
bind gaussian_brush_vertex_blend gbvb_checker u_chk (
    .i_clk, .i_rst_n, .i_valid(o_valid), .i_item(o_item)
);
`default_nettype wire

### tb/gaussian_brush_vertex_blend_checker.sv
// gaussian_brush_vertex_blend_checker: watches the command, config and result channels,
// predicts each slice result of a query and compares it; depends on gbvb_pkg
`default_nettype none
module gaussian_brush_vertex_blend_checker import gbvb_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire t_in_item    i_item,
    input  wire logic        i_valid,
    input  wire t_out_item   i_result,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    output      int          o_fail_count,
    output      int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPTS = 64;
    localparam int NSLC = 4;
    localparam int LUT_DEPTH = 256;

    logic [15:0] gauss_lut [LUT_DEPTH];
    logic [15:0] pt_x [NPTS];
    logic [15:0] pt_y [NPTS];
    logic [15:0] pt_var [NPTS];
    logic [63:0] pt_rgba [NPTS*NSLC];
    logic [63:0] bias_rgba [NSLC];
    logic [6:0]  cfg_points;
    logic [2:0]  cfg_slices;
    logic [15:0] cfg_bias;
    t_out_item   slice_colors_due [$];

    // exp(-i*16/depth) in Q0.16: series for exp(-i/depth), then four squarings
    initial begin
        logic [63:0] acc, term, y, q;
        for (int i = 0; i < LUT_DEPTH; i++) begin
            acc = 64'h1_0000_0000;
            term = 64'h1_0000_0000;
            y = (64'(i) << 32) / LUT_DEPTH;
            for (int k = 1; k <= 20; k++) begin
                term = ((term * y) >> 32) / 64'(k);
                if (k & 1) acc = (acc >= term) ? acc - term : 64'd0;
                else acc = acc + term;
            end
            if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
            for (int r = 0; r < 4; r++) acc = (acc * acc) >> 32;
            q = (acc + 64'h8000) >> 16;
            gauss_lut[i] = (q > 64'd65535) ? 16'hFFFF : q[15:0];
        end
        for (int i = 0; i < NPTS; i++) begin
            pt_x[i] = '0;
            pt_y[i] = '0;
            pt_var[i] = '0;
        end
        for (int i = 0; i < NPTS*NSLC; i++) pt_rgba[i] = '0;
    end

    function automatic logic [15:0] clip16(input logic [63:0] v);
        return (v > 64'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    // gaussian gain of one brush point at the vertex, Q8.24
    function automatic logic [63:0] point_gain(input int p, input logic [15:0] qx,
                                               input logic [15:0] qy);
        logic [63:0] v, dx, dy, d, idx;
        v = 64'(pt_var[p]);
        dx = (pt_x[p] > qx) ? 64'(pt_x[p] - qx) : 64'(qx - pt_x[p]);
        dy = (pt_y[p] > qy) ? 64'(pt_y[p] - qy) : 64'(qy - pt_y[p]);
        d = dx * dx + dy * dy;
        if (v == 0) return 64'd0;
        idx = (d * LUT_DEPTH) / ((v * v) << 21);
        if (idx >= LUT_DEPTH) return 64'd0;
        return ((64'(GAUSS_COEF_Q24) / v) * 64'(gauss_lut[idx])) >> 16;
    endfunction

    // blend all sources for every slice of a query and queue the results
    task automatic predict_query(input logic [15:0] qx, input logic [15:0] qy);
        int n, s;
        logic [63:0] sr, sg, sb, sa, w, inten, c;
        t_out_item r;
        n = (cfg_points > NPTS) ? NPTS : int'(cfg_points);
        s = (cfg_slices < 1) ? 1 : ((cfg_slices > NSLC) ? NSLC : int'(cfg_slices));
        for (int k = 0; k < s; k++) begin
            sr = 0; sg = 0; sb = 0; sa = 0;
            for (int p = -1; p < n; p++) begin
                c = (p < 0) ? bias_rgba[k] : pt_rgba[p*NSLC + k];
                w = (p < 0) ? (64'(cfg_bias) << 16) : point_gain(p, qx, qy);
                inten = 64'(c[15:0]) * w;
                sr += 64'(c[63:48]) * inten;
                sg += 64'(c[47:32]) * inten;
                sb += 64'(c[31:16]) * inten;
                sa += inten;
            end
            r.slice_out = 2'(k);
            if (sa != 0) begin
                r.red_out = clip16(sr / sa);
                r.green_out = clip16(sg / sa);
                r.blue_out = clip16(sb / sa);
                r.alpha_out = 16'hFFFF;
                r.was_normalized = 1'b1;
            end else begin
                r.red_out = clip16(sr >> 32);
                r.green_out = clip16(sg >> 32);
                r.blue_out = clip16(sb >> 32);
                r.alpha_out = clip16(sa >> 16);
                r.was_normalized = 1'b0;
            end
            r.last_slice = (k + 1 == s);
            slice_colors_due.push_back(r);
        end
    endtask

    task automatic note_mismatch(input string what, input t_out_item want,
                                 input t_out_item got);
        if (o_fail_count < 10)
            $display("%t mismatch %s: expected %h actual %h", $realtime, what, want, got);
        o_fail_count++;
    endtask

    // per edge: compare a result, then track config and command transactions
    always @(posedge i_clk) begin
        t_out_item want;
        logic [63:0] rgba;
        if (!i_rst_n) begin
            cfg_points <= 7'd0;
            cfg_slices <= 3'd2;
            cfg_bias <= 16'hFFFF;
            for (int i = 0; i < NSLC; i++) bias_rgba[i] = '0;
            slice_colors_due.delete();
        end else begin
            if (i_valid) begin
                if (slice_colors_due.size() == 0) begin
                    note_mismatch("unexpected result", '0, i_result);
                end else begin
                    want = slice_colors_due.pop_front();
                    if (i_result.slice_out !== want.slice_out ||
                        i_result.red_out !== want.red_out ||
                        i_result.green_out !== want.green_out ||
                        i_result.blue_out !== want.blue_out ||
                        i_result.alpha_out !== want.alpha_out ||
                        i_result.was_normalized !== want.was_normalized ||
                        i_result.last_slice !== want.last_slice)
                        note_mismatch("slice result", want, i_result);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_POINT_COUNT: cfg_points <= i_cfg_data[6:0];
                    CFG_SLICE_COUNT: cfg_slices <= i_cfg_data[2:0];
                    CFG_BIAS_WEIGHT: cfg_bias <= i_cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy) begin
                rgba = {i_item.red_in, i_item.green_in, i_item.blue_in, i_item.alpha_in};
                case (t_mode'(i_item.mode))
                    MODE_BIAS: bias_rgba[i_item.slice_select] = rgba;
                    MODE_BRUSH: begin
                        pt_x[i_item.entry_index] = i_item.pos_x;
                        pt_y[i_item.entry_index] = i_item.pos_y;
                        pt_var[i_item.entry_index] = i_item.variance;
                        pt_rgba[{i_item.entry_index, i_item.slice_select}] = rgba;
                    end
                    MODE_QUERY: predict_query(i_item.pos_x, i_item.pos_y);
                    default: ;
                endcase
            end
        end
        o_pending <= slice_colors_due.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end
endmodule
`default_nettype wire

### tb/gaussian_brush_vertex_blend_test.sv
// gaussian_brush_vertex_blend_test: clock, reset, command and config stimulus, verdict
// depends on gbvb_pkg, gaussian_brush_vertex_blend, gaussian_brush_vertex_blend_checker
`default_nettype none
module gaussian_brush_vertex_blend_test import gbvb_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IW = $bits(t_in_item);

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_in_item    i_item;
    logic        o_valid;
    t_out_item   o_item;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    int          fail_count;
    int          pending;

    bit          slot_loaded [64][4];
    int          cur_points;
    int          cur_slices;
    int          items_sent;
    bit          quiet;

    gaussian_brush_vertex_blend dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_item(i_item),
        .o_valid(o_valid), .o_item(o_item), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    gaussian_brush_vertex_blend_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_item(i_item),
        .i_valid(o_valid), .i_result(o_item), .i_cfg_valid(i_cfg_valid),
        .i_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // run limit
    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // one command transaction; optional idle burst first
    task automatic send_item(input t_in_item it);
        bit took;
        if (!quiet && $urandom_range(3) == 0) begin
            start = 1'b0;
            repeat ($urandom_range(8, 1)) @(negedge i_clk);
        end
        start = 1'b1;
        i_item = it;
        forever begin
            took = !busy;
            @(posedge i_clk);
            if (took) break;
            @(negedge i_clk);
        end
        @(negedge i_clk);
        start = 1'b0;
        if (it.mode == MODE_BRUSH) slot_loaded[it.entry_index][it.slice_select] = 1'b1;
        items_sent++;
    endtask

    function automatic t_in_item rand_item(input t_mode m);
        t_in_item it;
        it = IW'({$urandom, $urandom, $urandom, $urandom, $urandom});
        it.mode = m;
        if ($urandom_range(1)) begin
            // keep brush points close to the center so weights stay nonzero
            it.pos_x = 16'h8000 + 16'($urandom_range(4095)) - 16'd2048;
            it.pos_y = 16'h8000 + 16'($urandom_range(4095)) - 16'd2048;
        end
        case ($urandom_range(7))
            0: it.variance = 16'($urandom_range(3));
            1: it.variance = 16'($urandom_range(1024));
            default: ;
        endcase
        return it;
    endfunction

    task automatic send_load(input int slot, input int slc);
        t_in_item it;
        it = rand_item(MODE_BRUSH);
        it.entry_index = 6'(slot);
        it.slice_select = 2'(slc);
        send_item(it);
    endtask

    // load whatever slot or slice a query would read unwritten, then query
    task automatic send_query(input logic [15:0] qx, input logic [15:0] qy);
        t_in_item it;
        for (int p = 0; p < cur_points; p++)
            for (int k = 0; k < cur_slices; k++)
                if (!slot_loaded[p][k]) send_load(p, k);
        it = rand_item(MODE_QUERY);
        it.pos_x = qx;
        it.pos_y = qy;
        send_item(it);
    endtask

    // block idle: all results in, plus slack for a finishing load
    task automatic wait_idle();
        while (pending != 0 || busy) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] val);
        bit took;
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        forever begin
            took = o_cfg_ready;
            @(posedge i_clk);
            if (took) break;
            @(negedge i_clk);
        end
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_config(input int pts, input int slc, input logic [15:0] bw);
        wait_idle();
        write_reg(CFG_POINT_COUNT, 16'(pts));
        write_reg(CFG_SLICE_COUNT, 16'(slc));
        write_reg(CFG_BIAS_WEIGHT, bw);
        cur_points = (pts > 64) ? 64 : pts;
        cur_slices = (slc < 1) ? 1 : ((slc > 4) ? 4 : slc);
    endtask

    initial begin
        t_in_item it;
        int pick;
        logic [15:0] bw;
        start = 1'b0;
        i_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        quiet = 1'b0;
        items_sent = 0;
        cur_points = 0;
        cur_slices = 2;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // zero alpha sum: bias still zero and no points
        send_query(16'h0000, 16'h0000);
        // bias colors at the extremes
        for (int k = 0; k < 4; k++) begin
            it = rand_item(MODE_BIAS);
            it.slice_select = 2'(k);
            {it.red_in, it.green_in, it.blue_in} = (k & 1) ? '1 : '0;
            it.alpha_in = (k == 2) ? 16'h0000 : 16'hFFFF;
            send_item(it);
        end
        it = rand_item(MODE_NONE);
        send_item(it);
        send_query(16'hFFFF, 16'hFFFF);
        // exact hit, zero variance, far point
        set_config(3, 4, 16'h0000);
        for (int p = 0; p < 3; p++) begin
            it = rand_item(MODE_BRUSH);
            it.entry_index = 6'(p);
            it.slice_select = 2'd0;
            it.pos_x = (p == 2) ? 16'hFFFF : 16'h4000;
            it.pos_y = (p == 2) ? 16'hFFFF : 16'h4000;
            it.variance = (p == 1) ? 16'h0000 : ((p == 2) ? 16'h0001 : 16'hFFFF);
            it.alpha_in = 16'hFFFF;
            send_item(it);
        end
        send_query(16'h4000, 16'h4000);
        send_query(16'h0000, 16'h0000);

        // random phases of settings and traffic; sender drains once per phase
        while (items_sent < 80) begin
            pick = $urandom_range(3);
            bw = (pick == 0) ? 16'h0000 : ((pick == 1) ? 16'hFFFF : 16'($urandom));
            set_config($urandom_range(9), $urandom_range(7), bw);
            repeat (20) begin
                pick = $urandom_range(19);
                if (pick < 8) begin
                    send_load($urandom_range(cur_points + 2), $urandom_range(3));
                end else if (pick < 10) begin
                    send_item(rand_item(MODE_BIAS));
                end else if (pick == 10) begin
                    send_item(rand_item(MODE_NONE));
                end else begin
                    it = rand_item(MODE_QUERY);
                    send_query(it.pos_x, it.pos_y);
                end
            end
        end

        // no idling: point count above range clamps to all slots, one slice
        quiet = 1'b1;
        set_config(127, 1, 16'($urandom));
        for (int q = 0; q < 3; q++) begin
            it = rand_item(MODE_QUERY);
            send_query(16'h8000 + 16'($urandom_range(511)), 16'h8000 - 16'($urandom_range(511)));
        end

        while (pending != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
